// ===== src/assert_macros.svh =====
// Assertion macros shared by the servo command framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, held off while rst_n is low.
`define SACF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("servo framer check failed");

// Same check, also evaluated during reset.
`define SACF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("servo framer check failed during or after reset");

`endif

// ===== src/sacf_pkg.sv =====
// Types, constants and helper functions for the servo command framer.
`timescale 1ns / 1ps
`default_nettype none

package sacf_pkg;

  localparam int unsigned FRAME_LEN = 17;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  // Byte positions within the frame.
  localparam logic [CNT_W-1:0] POS_HASH  = 5'd0;
  localparam logic [CNT_W-1:0] POS_ID2   = 5'd1;
  localparam logic [CNT_W-1:0] POS_ID1   = 5'd2;
  localparam logic [CNT_W-1:0] POS_ID0   = 5'd3;
  localparam logic [CNT_W-1:0] POS_P     = 5'd4;
  localparam logic [CNT_W-1:0] POS_PW3   = 5'd5;
  localparam logic [CNT_W-1:0] POS_PW2   = 5'd6;
  localparam logic [CNT_W-1:0] POS_PW1   = 5'd7;
  localparam logic [CNT_W-1:0] POS_PW0   = 5'd8;
  localparam logic [CNT_W-1:0] POS_T     = 5'd9;
  localparam logic [CNT_W-1:0] POS_RT3   = 5'd10;
  localparam logic [CNT_W-1:0] POS_RT2   = 5'd11;
  localparam logic [CNT_W-1:0] POS_RT1   = 5'd12;
  localparam logic [CNT_W-1:0] POS_RT0   = 5'd13;
  localparam logic [CNT_W-1:0] POS_BANG  = 5'd14;
  localparam logic [CNT_W-1:0] POS_CR    = 5'd15;
  localparam logic [CNT_W-1:0] POS_LF    = 5'd16;

  // ASCII codes.
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // Field widths and saturation limits.
  localparam int unsigned ID_W  = 10;
  localparam int unsigned VAL_W = 14;
  localparam logic [ID_W-1:0]  ID_MAX  = 10'd999;
  localparam logic [VAL_W-1:0] VAL_MAX = 14'd9999;

  // Divide by ten: q = (v * 52429) >> 19, exact for v below 43699.
  localparam int unsigned       RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP  = 16'd52429;
  localparam int unsigned       PROD_W  = VAL_W + RECIP_W;
  localparam int unsigned       RECIP_SHIFT = 19;
  localparam int unsigned       QUOT_W  = PROD_W - RECIP_SHIFT;

  typedef logic [3:0] bcd_t;

  // Work item travelling down the conversion pipeline.
  typedef struct packed {
    logic [ID_W-1:0]  id_v;
    logic [VAL_W-1:0] pw_v;
    logic [VAL_W-1:0] rt_v;
    bcd_t [2:0]       id_d;
    bcd_t [2:0]       pw_d;
    bcd_t [2:0]       rt_d;
  } sacf_work_t;

  // Finished command, all digits, least significant at index 0.
  typedef struct packed {
    bcd_t [2:0] id_d;
    bcd_t [3:0] pw_d;
    bcd_t [3:0] rt_d;
  } sacf_digits_t;

  function automatic logic [QUOT_W-1:0] div10(input logic [VAL_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(RECIP);
    return p[PROD_W-1:RECIP_SHIFT];
  endfunction

  function automatic bcd_t rem10(input logic [VAL_W-1:0] v, input logic [QUOT_W-1:0] q);
    logic [VAL_W-1:0] q10;
    q10 = VAL_W'({q, 3'b000}) + VAL_W'({q, 1'b0});
    return bcd_t'(v - q10);
  endfunction

endpackage

`default_nettype wire

// ===== src/sacf_front.sv =====
// Front end: saturate the command and split each field into decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module sacf_front
  import sacf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire logic [ID_W-1:0]    cmd_id,
  input  wire logic [VAL_W-1:0]   cmd_pw,
  input  wire logic [VAL_W-1:0]   cmd_rt,
  output logic                    dig_valid,
  input  wire logic               dig_ready,
  output sacf_digits_t            dig_data
);

  localparam int unsigned NSTG = 4;

  logic [NSTG-1:0] stg_v_r;
  logic [NSTG-1:0] stg_v_nxt;
  logic [NSTG-1:0] stg_rdy;
  sacf_work_t      stg_r   [NSTG];
  sacf_work_t      stg_nxt [NSTG];

  // A stage may load when empty or when its content moves on.
  always_comb begin
    stg_rdy[NSTG-1] = !stg_v_r[NSTG-1] || dig_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_rdy[i] = !stg_v_r[i] || stg_rdy[i+1];
    end
  end

  assign cmd_ready = stg_rdy[0];

  // Stage 0 saturates; each later stage peels one digit off every lane.
  always_comb begin
    logic [QUOT_W-1:0] q_id;
    logic [QUOT_W-1:0] q_pw;
    logic [QUOT_W-1:0] q_rt;
    stg_nxt[0]      = '0;
    stg_nxt[0].id_v = (cmd_id > ID_MAX) ? ID_MAX : cmd_id;
    stg_nxt[0].pw_v = (cmd_pw > VAL_MAX) ? VAL_MAX : cmd_pw;
    stg_nxt[0].rt_v = (cmd_rt > VAL_MAX) ? VAL_MAX : cmd_rt;
    stg_v_nxt[0]    = cmd_valid;
    for (int k = 0; k < NSTG - 1; k++) begin
      q_id = div10(VAL_W'(stg_r[k].id_v));
      q_pw = div10(stg_r[k].pw_v);
      q_rt = div10(stg_r[k].rt_v);
      stg_nxt[k+1]         = stg_r[k];
      stg_nxt[k+1].id_d[k] = rem10(VAL_W'(stg_r[k].id_v), q_id);
      stg_nxt[k+1].pw_d[k] = rem10(stg_r[k].pw_v, q_pw);
      stg_nxt[k+1].rt_d[k] = rem10(stg_r[k].rt_v, q_rt);
      stg_nxt[k+1].id_v    = ID_W'(q_id);
      stg_nxt[k+1].pw_v    = VAL_W'(q_pw);
      stg_nxt[k+1].rt_v    = VAL_W'(q_rt);
      stg_v_nxt[k+1]       = stg_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (stg_rdy[i]) begin
          stg_v_r[i] <= stg_v_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (stg_rdy[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  // The quotient left after three divisions is the leading digit of the wide lanes.
  assign dig_valid     = stg_v_r[NSTG-1];
  assign dig_data.id_d = stg_r[NSTG-1].id_d;
  assign dig_data.pw_d = {bcd_t'(stg_r[NSTG-1].pw_v), stg_r[NSTG-1].pw_d};
  assign dig_data.rt_d = {bcd_t'(stg_r[NSTG-1].rt_v), stg_r[NSTG-1].rt_d};

endmodule

`default_nettype wire

// ===== src/sacf_fifo.sv =====
// Two-entry queue of converted commands between front and back.
`timescale 1ns / 1ps
`default_nettype none

module sacf_fifo
  import sacf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire sacf_digits_t  wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output sacf_digits_t       rd_data
);

  sacf_digits_t mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/sacf_back.sv =====
// Back end: serialise one converted command into its 17-byte ASCII frame.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sacf_back
  import sacf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          dig_valid,
  output logic               dig_ready,
  input  wire sacf_digits_t  dig_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_char,
  output logic               out_last
);

  sacf_digits_t     cur_r, cur_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       och_r, och_nxt;
  logic             olast_r, olast_nxt;
  logic             load_out, emit, pop, at_end;
  logic [7:0]       ch;

  assign load_out  = !ov_r || out_ready;
  assign emit      = busy_r && load_out;
  assign at_end    = (cnt_r == POS_LF);
  assign pop       = dig_valid && (!busy_r || (emit && at_end));
  assign dig_ready = !busy_r || (emit && at_end);

  always_comb begin
    unique case (cnt_r)
      POS_HASH: ch = CH_HASH;
      POS_ID2:  ch = ASCII_ZERO + 8'(cur_r.id_d[2]);
      POS_ID1:  ch = ASCII_ZERO + 8'(cur_r.id_d[1]);
      POS_ID0:  ch = ASCII_ZERO + 8'(cur_r.id_d[0]);
      POS_P:    ch = CH_P;
      POS_PW3:  ch = ASCII_ZERO + 8'(cur_r.pw_d[3]);
      POS_PW2:  ch = ASCII_ZERO + 8'(cur_r.pw_d[2]);
      POS_PW1:  ch = ASCII_ZERO + 8'(cur_r.pw_d[1]);
      POS_PW0:  ch = ASCII_ZERO + 8'(cur_r.pw_d[0]);
      POS_T:    ch = CH_T;
      POS_RT3:  ch = ASCII_ZERO + 8'(cur_r.rt_d[3]);
      POS_RT2:  ch = ASCII_ZERO + 8'(cur_r.rt_d[2]);
      POS_RT1:  ch = ASCII_ZERO + 8'(cur_r.rt_d[1]);
      POS_RT0:  ch = ASCII_ZERO + 8'(cur_r.rt_d[0]);
      POS_BANG: ch = CH_BANG;
      POS_CR:   ch = CH_CR;
      POS_LF:   ch = CH_LF;
      default:  ch = 8'h00;
    endcase
  end

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (emit) begin
      ov_nxt    = 1'b1;
      och_nxt   = ch;
      olast_nxt = at_end;
      cnt_nxt   = at_end ? POS_HASH : cnt_r + 1'b1;
      busy_nxt  = !at_end;
    end
    if (pop) begin
      cur_nxt  = dig_data;
      busy_nxt = 1'b1;
      cnt_nxt  = POS_HASH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= POS_HASH;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ov_r;
  assign out_char  = och_r;
  assign out_last  = olast_r;

  `SACF_ASSERT(a_last_is_lf, ov_r && olast_r |-> och_r == CH_LF)
  `SACF_ASSERT(a_pop_at_frame_end, pop |-> !busy_r || (emit && cnt_r == POS_LF))
  `SACF_ASSERT(a_cnt_in_frame, cnt_r <= POS_LF)

endmodule

`default_nettype wire

// ===== src/servo_ascii_command_framer_unit.sv =====
// Top level of the servo ASCII command framer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one servo command per input beat (servo number, pulse width, run
// time) and emits its frame "#nnnPppppTtttt!\r\n" as 17 output beats of one
// ASCII byte each, tlast high on the line feed. Fields are always zero-padded;
// a servo number above 999 prints as 999, a pulse width or run time above
// 9999 prints as 9999. The byte serialiser drives the output register one
// byte a cycle unless the receiver holds out_tready low. On its way to the
// first output byte a command passes four conversion stages (saturation, then
// one decimal digit a stage per field by reciprocal multiplication), the
// two-entry command queue, the register holding the frame being sent and the
// output register. The front keeps taking commands while the back is still
// sending, until the queue and the conversion stages are full.
module servo_ascii_command_framer_unit
  import sacf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: [9:0] servo_id, [23:10] pulse_width, [37:24] run_time, [39:38] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: [7:0] char_code
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic         fr_valid, fr_ready;
  sacf_digits_t fr_data;
  logic         q_valid, q_ready;
  sacf_digits_t q_data;

  // Convert: saturate and split into BCD digits.
  sacf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd_id    (in_tdata[9:0]),
    .cmd_pw    (in_tdata[23:10]),
    .cmd_rt    (in_tdata[37:24]),
    .dig_valid (fr_valid),
    .dig_ready (fr_ready),
    .dig_data  (fr_data)
  );

  // Decouple conversion from transmission.
  sacf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Serialise one frame, one byte a beat.
  sacf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_valid (q_valid),
    .dig_ready (q_ready),
    .dig_data  (q_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the servo ASCII command framer.
`timescale 1ns / 1ps

module tb;
  import sacf_pkg::*;

  // Cycles with no beat on either side before the run is abandoned. The slowest
  // correct gap is a sender burst, the conversion pipeline and a receiver
  // burst.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // Bytes still owed by the block, oldest first.
  frame_byte_t frame_bytes_due[$];

  bit          idle_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned commands_sent = 0;
  int unsigned commands_clamped = 0;
  int unsigned bytes_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  servo_ascii_command_framer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One decimal digit of v as ASCII; scale picks the digit (1, 10, 100, ...).
  function automatic logic [7:0] decimal_char(input int unsigned v, input int unsigned scale);
    return ASCII_ZERO + 8'((v / scale) % 10);
  endfunction

  // Work out the frame for one command and queue its bytes.
  function automatic void push_frame(input logic [ID_W-1:0] id, input logic [VAL_W-1:0] pw,
                                     input logic [VAL_W-1:0] rt);
    int unsigned id_sat;
    int unsigned pw_sat;
    int unsigned rt_sat;
    logic [7:0]  line [0:FRAME_LEN-1];
    id_sat = (id > ID_MAX) ? int'(ID_MAX) : int'(id);
    pw_sat = (pw > VAL_MAX) ? int'(VAL_MAX) : int'(pw);
    rt_sat = (rt > VAL_MAX) ? int'(VAL_MAX) : int'(rt);
    line[POS_HASH] = CH_HASH;
    line[POS_ID2]  = decimal_char(id_sat, 100);
    line[POS_ID1]  = decimal_char(id_sat, 10);
    line[POS_ID0]  = decimal_char(id_sat, 1);
    line[POS_P]    = CH_P;
    line[POS_PW3]  = decimal_char(pw_sat, 1000);
    line[POS_PW2]  = decimal_char(pw_sat, 100);
    line[POS_PW1]  = decimal_char(pw_sat, 10);
    line[POS_PW0]  = decimal_char(pw_sat, 1);
    line[POS_T]    = CH_T;
    line[POS_RT3]  = decimal_char(rt_sat, 1000);
    line[POS_RT2]  = decimal_char(rt_sat, 100);
    line[POS_RT1]  = decimal_char(rt_sat, 10);
    line[POS_RT0]  = decimal_char(rt_sat, 1);
    line[POS_BANG] = CH_BANG;
    line[POS_CR]   = CH_CR;
    line[POS_LF]   = CH_LF;
    for (int unsigned k = 0; k < FRAME_LEN; k++) begin
      frame_bytes_due.push_back('{ch: line[k], last: (k == FRAME_LEN - 1)});
    end
  endfunction

  // Offer one command and hold it until the block takes the beat. Valid stays
  // high after acceptance so back-to-back commands never toggle it in one step.
  task automatic send_command(input logic [ID_W-1:0] id, input logic [VAL_W-1:0] pw,
                              input logic [VAL_W-1:0] rt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata  <= {2'b00, rt, pw, id};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    push_frame(id, pw, rt);
    commands_sent++;
    if (id > ID_MAX || pw > VAL_MAX || rt > VAL_MAX) commands_clamped++;
  endtask

  // Zero, single-digit, digit-boundary and top-of-range values of every field.
  task automatic test_field_extremes();
    send_command(10'd0, 14'd0, 14'd0);
    send_command(10'd999, 14'd9999, 14'd9999);
    send_command(10'd1, 14'd1, 14'd1);
    send_command(10'd9, 14'd9, 14'd9);
    send_command(10'd10, 14'd10, 14'd10);
    send_command(10'd99, 14'd99, 14'd99);
    send_command(10'd100, 14'd100, 14'd100);
    send_command(10'd998, 14'd999, 14'd1000);
    send_command(10'd0, 14'd9998, 14'd0);
    send_command(10'd512, 14'd8192, 14'd4096);
    send_command(10'd341, 14'd5461, 14'd2730);
    send_command(10'd1, 14'd500, 14'd1000);
    send_command(10'd254, 14'd2500, 14'd0);
  endtask

  // Values above each field's range must print as all nines.
  task automatic test_saturation();
    send_command(10'd1000, 14'd10000, 14'd10000);
    send_command(10'd1023, 14'd16383, 14'd16383);
    send_command(10'd1023, 14'd0, 14'd0);
    send_command(10'd0, 14'd16383, 14'd0);
    send_command(10'd0, 14'd0, 14'd16383);
    send_command(10'd682, 14'd10922, 14'd10922);
    send_command(10'd999, 14'd10000, 14'd9999);
  endtask

  // Mostly in-range commands, some typical servo traffic, some raw bit patterns.
  // Drop idling for a stretch in the middle so full-rate streaming is seen too.
  task automatic test_random_commands(input int unsigned count);
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] pw;
    logic [VAL_W-1:0] rt;
    int unsigned      pick;
    for (int unsigned n = 0; n < count; n++) begin
      idle_on = (n < count / 2) || (n >= count / 2 + 40);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        id = ID_W'($urandom_range(0, 1023));
        pw = VAL_W'($urandom_range(0, 16383));
        rt = VAL_W'($urandom_range(0, 16383));
      end else if (pick < 5) begin
        id = ID_W'($urandom_range(0, 31));
        pw = VAL_W'($urandom_range(500, 2500));
        rt = VAL_W'($urandom_range(0, 2000));
      end else begin
        id = ID_W'($urandom_range(0, 999));
        pw = VAL_W'($urandom_range(0, 9999));
        rt = VAL_W'($urandom_range(0, 9999));
      end
      send_command(id, pw, rt);
    end
  endtask

  // Final stretch: no idling on either side.
  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      send_command(ID_W'($urandom_range(0, 1023)), VAL_W'($urandom_range(0, 16383)),
                   VAL_W'($urandom_range(0, 9999)));
    end
  endtask

  // Check each output beat against the oldest owed byte, then pick the next
  // ready level: random stall bursts while idling is on.
  always @(posedge clk) begin : frame_checker
    frame_byte_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual char 0x%02h last %0b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        due = frame_bytes_due.pop_front();
        bytes_checked++;
        if (out_tdata !== due.ch) begin
          $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                   $time, due.ch, out_tdata);
          mismatches++;
        end
        if (out_tlast !== due.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, due.last, out_tlast);
          mismatches++;
        end
        if (due.last) frames_closed++;
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abandon the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d bytes still owed",
                 $time, QUIET_LIMIT, frame_bytes_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_saturation();
    test_random_commands(220);
    test_back_to_back(30);
    in_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += frame_bytes_due.size();
    $display("Framed %0d servo commands (%0d with clamped fields) under random stalls,",
             commands_sent, commands_clamped);
    $display("then back to back; checked %0d bytes and %0d frame ends.",
             bytes_checked, frames_closed);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
